// File: rtl/core/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types and constants of the bilinear RGB565 scaler core.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

    // Frame store geometry and fixed point format
    localparam int SRC_DEPTH = 262144;
    localparam int FRAC_BITS = 16;
    localparam int ADDR_W    = $clog2(SRC_DEPTH);

    // Field widths
    localparam int WIDTH_W = 11;
    localparam int STEP_W  = 26;
    localparam int COORD_W = 10;
    localparam int INDEX_W = 18;
    localparam int PIX_W   = 24;
    localparam int CFG_IDX_W = 2;

    // Derived arithmetic widths
    localparam int POS_W  = COORD_W + STEP_W;        // full Q position
    localparam int INT_W  = POS_W - FRAC_BITS;       // integer part
    localparam int PROD_W = INT_W + WIDTH_W;         // row * pitch
    localparam int IDX_W  = PROD_W + 2;              // neighbour index
    localparam int WGT_W  = 17;                      // weight 0..65536
    localparam int ACC_W  = 24;                      // 255 * 65536 fits
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH = 2'd0,
        CFG_X_STEP    = 2'd1,
        CFG_Y_STEP    = 2'd2
    } t_cfg_idx;

    // Command passed from front to back
    typedef struct packed {
        logic                        is_fetch;
        logic                        oor;      // fetch beyond store, or load dropped
        logic [ADDR_W-1:0]           addr0;    // top-left (or load address)
        logic [ADDR_W-1:0]           addr2;    // bottom-left
        logic [PIX_W-1:0]            pix;
        logic [3:0][WGT_W-1:0]       wgt;      // w00, w01, w10, w11
    } t_cmd;

endpackage

`default_nettype wire

// File: rtl/core/bsr_front.sv
// ----------------------------------------------------------------------------
// bsr_front
// Accepts beats, computes source position, neighbour indexes and weights.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_req_type,
    input  wire logic [bsr_pkg::INDEX_W-1:0] i_src_index,
    input  wire logic [bsr_pkg::PIX_W-1:0]   i_pixel_rgb,
    input  wire logic [bsr_pkg::COORD_W-1:0] i_dst_x,
    input  wire logic [bsr_pkg::COORD_W-1:0] i_dst_y,
    input  wire logic [bsr_pkg::WIDTH_W-1:0] i_src_width,
    input  wire logic [bsr_pkg::STEP_W-1:0]  i_x_step,
    input  wire logic [bsr_pkg::STEP_W-1:0]  i_y_step,
    output logic                             o_cmd_valid,
    output bsr_pkg::t_cmd                    o_cmd,
    input  wire logic                        i_q_full
);
    import bsr_pkg::*;

    logic              adv;
    logic              r_v1, r_v2, r_v3;

    // stage 1: positions
    logic              r1_fetch;
    logic [INDEX_W-1:0] r1_index;
    logic [PIX_W-1:0]  r1_pix;
    logic [POS_W-1:0]  r1_px, r1_py;

    // stage 2: row offset, weights
    logic              r2_fetch;
    logic [INDEX_W-1:0] r2_index;
    logic [PIX_W-1:0]  r2_pix;
    logic [PROD_W-1:0] r2_prod;
    logic [INT_W-1:0]  r2_sx;
    logic [3:0][WGT_W-1:0] r2_wgt;

    // stage 3: finished command
    t_cmd              r3_cmd;

    logic [7:0]        fx, fy;
    logic [8:0]        gx, gy;
    logic [IDX_W-1:0]  idx0, idx2, idx3;
    t_cmd              n_cmd;

    // whole pipe moves unless the last stage is blocked by a full queue
    assign adv        = !(r_v3 && i_q_full);
    assign o_in_stall = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // weight terms
    always_comb begin
        fx = r1_px[FRAC_BITS-1 -: 8];
        fy = r1_py[FRAC_BITS-1 -: 8];
        gx = 9'd256 - {1'b0, fx};
        gy = 9'd256 - {1'b0, fy};
    end

    // neighbour indexes and range check
    always_comb begin
        idx0 = IDX_W'(r2_prod) + IDX_W'(r2_sx);
        idx2 = idx0 + IDX_W'(i_src_width);
        idx3 = idx2 + IDX_W'(1);
        n_cmd.is_fetch = r2_fetch;
        n_cmd.pix      = r2_pix;
        n_cmd.wgt      = r2_wgt;
        n_cmd.addr2    = idx2[ADDR_W-1:0];
        if (r2_fetch) begin
            n_cmd.oor   = (idx3 >= IDX_W'(SRC_DEPTH));
            n_cmd.addr0 = idx0[ADDR_W-1:0];
        end else begin
            n_cmd.oor   = !(IDX_W'(r2_index) < IDX_W'(SRC_DEPTH));
            n_cmd.addr0 = ADDR_W'(r2_index);
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_fetch <= i_req_type;
            r1_index <= i_src_index;
            r1_pix   <= i_pixel_rgb;
            r1_px    <= POS_W'(i_dst_x) * POS_W'(i_x_step);
            r1_py    <= POS_W'(i_dst_y) * POS_W'(i_y_step);

            r2_fetch <= r1_fetch;
            r2_index <= r1_index;
            r2_pix   <= r1_pix;
            r2_prod  <= PROD_W'(r1_py[POS_W-1:FRAC_BITS]) * PROD_W'(i_src_width);
            r2_sx    <= r1_px[POS_W-1:FRAC_BITS];
            r2_wgt[0] <= WGT_W'(gx) * WGT_W'(gy);
            r2_wgt[1] <= WGT_W'(fx) * WGT_W'(gy);
            r2_wgt[2] <= WGT_W'(gx) * WGT_W'(fy);
            r2_wgt[3] <= WGT_W'(fx) * WGT_W'(fy);

            r3_cmd   <= n_cmd;
        end
    end

    assign o_cmd_valid = r_v3;
    assign o_cmd       = r3_cmd;

endmodule

`default_nettype wire

// File: rtl/core/bsr_queue.sv
// ----------------------------------------------------------------------------
// bsr_queue
// Short command queue decoupling the front pipe from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire bsr_pkg::t_cmd  i_cmd,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output bsr_pkg::t_cmd       o_head
);
    import bsr_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end

endmodule

`default_nettype wire

// File: rtl/core/bsr_back.sv
// ----------------------------------------------------------------------------
// bsr_back
// Frame store, four neighbour reads per in-range fetch and the blend accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_q_empty,
    input  wire bsr_pkg::t_cmd  i_head,
    output logic                o_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output logic [7:0]          o_red,
    output logic [7:0]          o_green,
    output logic [7:0]          o_blue,
    output logic [15:0]         o_rgb565,
    output logic                o_out_of_range
);
    import bsr_pkg::*;

    logic [PIX_W-1:0]  r_mem [SRC_DEPTH];
    logic [PIX_W-1:0]  r_rd;

    logic              adv;
    logic [1:0]        r_k;
    logic              go;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;

    // issued read tag, aligned with r_rd
    logic              r_tv, r_tfirst, r_tlast, r_toor;
    logic [WGT_W-1:0]  r_tw;
    logic              n_tv, n_tfirst, n_tlast, n_toor;

    logic [2:0][ACC_W-1:0] r_acc;
    logic [2:0][ACC_W-1:0] sum;

    logic              r_ov, r_oor;
    logic [7:0]        r_red, r_green, r_blue;

    // back end freezes while a finished result is held by the receiver
    assign adv = !r_ov || !i_out_stall;
    assign go  = adv && !i_q_empty;

    // issue: one load per cycle while not frozen, four reads per in-range fetch, one tag per out-of-range fetch
    always_comb begin
        mem_we   = 1'b0;
        o_pop    = 1'b0;
        n_tv     = 1'b0;
        n_tfirst = 1'b0;
        n_tlast  = 1'b0;
        n_toor   = 1'b0;
        mem_addr = (r_k[1] ? i_head.addr2 : i_head.addr0) + ADDR_W'(r_k[0]);
        if (go) begin
            if (!i_head.is_fetch) begin
                mem_we   = !i_head.oor;
                mem_addr = i_head.addr0;
                o_pop    = 1'b1;
            end else if (i_head.oor) begin
                n_tv     = 1'b1;
                n_tfirst = 1'b1;
                n_tlast  = 1'b1;
                n_toor   = 1'b1;
                o_pop    = 1'b1;
            end else begin
                n_tv     = 1'b1;
                n_tfirst = (r_k == 2'd0);
                n_tlast  = (r_k == 2'd3);
                o_pop    = (r_k == 2'd3);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_tv <= 1'b0;
            r_ov <= 1'b0;
        end else if (adv) begin
            if (go && i_head.is_fetch && !i_head.oor) r_k <= r_k + 1'b1;
            r_tv <= n_tv;
            r_ov <= r_tv && r_tlast;
        end
    end

    // single-port frame store
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (mem_we) r_mem[mem_addr] <= i_head.pix;
            r_rd <= r_mem[mem_addr];
        end
    end

    // tag payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tfirst <= n_tfirst;
            r_tlast  <= n_tlast;
            r_toor   <= n_toor;
            r_tw     <= i_head.wgt[r_k];
        end
    end

    // per-channel multiply-accumulate
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum[c] = (r_tfirst ? '0 : r_acc[c])
                   + ACC_W'(ACC_W'(r_rd[8*c +: 8]) * ACC_W'(r_tw));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_tv) begin
            r_acc <= sum;
            if (r_tlast) begin
                r_oor   <= r_toor;
                r_red   <= r_toor ? 8'd0 : sum[2][ACC_W-1 -: 8];
                r_green <= r_toor ? 8'd0 : sum[1][ACC_W-1 -: 8];
                r_blue  <= r_toor ? 8'd0 : sum[0][ACC_W-1 -: 8];
            end
        end
    end

    assign o_out_valid    = r_ov;
    assign o_red          = r_red;
    assign o_green        = r_green;
    assign o_blue         = r_blue;
    assign o_rgb565       = {r_red[7:3], r_green[7:2], r_blue[7:3]};
    assign o_out_of_range = r_oor;

    // read counter only runs on an in-range fetch at the queue head
    a_k_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k != 2'd0 |-> !i_q_empty && i_head.is_fetch && !i_head.oor)
        else $error("read counter active without fetch at head");

    // a continuing tag always follows another tag
    a_tag_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv && !r_tfirst |-> $past(r_tv))
        else $error("tag chain broken");

    // out-of-range result carries zero color
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && r_oor |-> o_rgb565 == 16'd0)
        else $error("out-of-range result not zero");

endmodule

`default_nettype wire

// File: rtl/core/bilinear_scaler_rgb565_core.sv
// ----------------------------------------------------------------------------
// bilinear_scaler_rgb565_core
// Bilinear scaler: RGB888 frame store, RGB888 + RGB565 output pixels.
// ----------------------------------------------------------------------------
// Input channel (valid/stall): a beat with req_type 0 loads pixel_rgb at
// src_index into the frame store and yields no result; req_type 1 fetches
// output pixel (dst_x, dst_y) and yields one result beat.
// Output channel (valid/stall): red, green, blue, rgb565, out_of_range.
// Config port: i_cfg_we writes src_width (0), x_step (1), y_step (2).
// Write config only while the core is idle.
// A fetch passes the 3-stage front, the queue, four store reads, the
// accumulator and the output register; a fetch whose neighbours lie beyond
// the store skips the reads and passes a single tag instead.
// A load is a single store write and an in-range fetch four neighbour reads
// through the single store port. Input beats are taken every cycle until
// the 4-entry command queue fills.
// Reset clears pipeline and queue control and sets src_width 320 and both
// steps to 1.0; store contents are undefined until loaded.
// While the receiver stalls, the held result stays put, the back end
// freezes and the front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_scaler_rgb565_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [bsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [bsr_pkg::STEP_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_req_type,
    input  wire logic [bsr_pkg::INDEX_W-1:0]   i_src_index,
    input  wire logic [bsr_pkg::PIX_W-1:0]     i_pixel_rgb,
    input  wire logic [bsr_pkg::COORD_W-1:0]   i_dst_x,
    input  wire logic [bsr_pkg::COORD_W-1:0]   i_dst_y,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [7:0]                         o_red,
    output logic [7:0]                         o_green,
    output logic [7:0]                         o_blue,
    output logic [15:0]                        o_rgb565,
    output logic                               o_out_of_range
);
    import bsr_pkg::*;

    logic [WIDTH_W-1:0] r_src_width;
    logic [STEP_W-1:0]  r_x_step, r_y_step;

    logic  cmd_valid, q_full, q_empty, pop, push;
    t_cmd  cmd, head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width <= WIDTH_W'(320);
            r_x_step    <= STEP_W'(65536);
            r_y_step    <= STEP_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SRC_WIDTH: r_src_width <= i_cfg_data[WIDTH_W-1:0];
                CFG_X_STEP:    r_x_step    <= i_cfg_data;
                CFG_Y_STEP:    r_y_step    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bsr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .i_src_index (i_src_index),
        .i_pixel_rgb (i_pixel_rgb),
        .i_dst_x     (i_dst_x),
        .i_dst_y     (i_dst_y),
        .i_src_width (r_src_width),
        .i_x_step    (r_x_step),
        .i_y_step    (r_y_step),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_q_full    (q_full)
    );

    assign push = cmd_valid && !q_full;

    bsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_head  (head)
    );

    bsr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_rgb565       (o_rgb565),
        .o_out_of_range (o_out_of_range)
    );

endmodule

`default_nettype wire

// File: sim/bilinear_scaler_rgb565_core_check.sv
// ----------------------------------------------------------------------------
// bilinear_scaler_rgb565_core_check
// Watches the scaler's config port and both channels, keeps its own copy of
// the frame store and registers, predicts each fetch result and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bilinear_scaler_rgb565_core_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bsr_pkg::STEP_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic                          i_req_type,
    input  logic [bsr_pkg::INDEX_W-1:0]   i_src_index,
    input  logic [bsr_pkg::PIX_W-1:0]     i_pixel_rgb,
    input  logic [bsr_pkg::COORD_W-1:0]   i_dst_x,
    input  logic [bsr_pkg::COORD_W-1:0]   i_dst_y,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [7:0]                    i_red,
    input  logic [7:0]                    i_green,
    input  logic [7:0]                    i_blue,
    input  logic [15:0]                   i_rgb565,
    input  logic                          i_out_of_range,
    output int                            o_fail_count,
    output int                            o_pending
);
    import bsr_pkg::*;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] rgb565;
        logic        oor;
    } t_pixel_out;

    logic [PIX_W-1:0]   frame_copy [SRC_DEPTH];
    logic [WIDTH_W-1:0] pitch;
    logic [STEP_W-1:0]  step_x;
    logic [STEP_W-1:0]  step_y;
    t_pixel_out         pixels_due [$];

    assign o_pending = pixels_due.size();

    // one channel of the four-tap blend, truncated
    function automatic logic [7:0] mix_channel(input logic [7:0] p00, input logic [7:0] p01,
                                               input logic [7:0] p10, input logic [7:0] p11,
                                               input int fx, input int fy);
        longint acc;
        acc = p00 * (256 - fx) * (256 - fy) + p01 * fx * (256 - fy)
            + p10 * (256 - fx) * fy + p11 * fx * fy;
        return acc[23:16];
    endfunction

    // expected output pixel for a fetch at (x, y) under the current registers
    function automatic t_pixel_out scale_pixel(input logic [COORD_W-1:0] x,
                                               input logic [COORD_W-1:0] y);
        t_pixel_out       res;
        longint unsigned  px, py, i0, i2;
        int               fx, fy;
        logic [PIX_W-1:0] p00, p01, p10, p11;
        px  = longint'(x) * step_x;
        py  = longint'(y) * step_y;
        fx  = int'((px >> (FRAC_BITS - 8)) & 8'hFF);
        fy  = int'((py >> (FRAC_BITS - 8)) & 8'hFF);
        i0  = (py >> FRAC_BITS) * pitch + (px >> FRAC_BITS);
        i2  = i0 + pitch;
        res = '0;
        if (i2 + 1 >= SRC_DEPTH) begin
            res.oor = 1'b1;
            return res;
        end
        p00 = frame_copy[i0];
        p01 = frame_copy[i0 + 1];
        p10 = frame_copy[i2];
        p11 = frame_copy[i2 + 1];
        res.red    = mix_channel(p00[23:16], p01[23:16], p10[23:16], p11[23:16], fx, fy);
        res.green  = mix_channel(p00[15:8], p01[15:8], p10[15:8], p11[15:8], fx, fy);
        res.blue   = mix_channel(p00[7:0], p01[7:0], p10[7:0], p11[7:0], fx, fy);
        res.rgb565 = {res.red[7:3], res.green[7:2], res.blue[7:3]};
        return res;
    endfunction

    // track registers, store loads, and compare result beats
    always @(posedge i_clk) begin
        t_pixel_out exp_pix;
        if (!i_rst_n) begin
            pitch        <= WIDTH_W'(320);
            step_x       <= STEP_W'(65536);
            step_y       <= STEP_W'(65536);
            o_fail_count <= 0;
            pixels_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SRC_WIDTH: pitch  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_X_STEP:    step_x <= i_cfg_data;
                    CFG_Y_STEP:    step_y <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (!i_req_type) frame_copy[i_src_index] = i_pixel_rgb;
                else             pixels_due.push_back(scale_pixel(i_dst_x, i_dst_y));
            end
            if (i_out_valid && !i_out_stall) begin
                if (pixels_due.size() == 0) begin
                    $display("%0t: result beat with nothing expected, got %h %h %h %h %b",
                             $time, i_red, i_green, i_blue, i_rgb565, i_out_of_range);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_pix = pixels_due.pop_front();
                    if (exp_pix != {i_red, i_green, i_blue, i_rgb565, i_out_of_range}) begin
                        $display("%0t: pixel mismatch exp r%h g%h b%h 565=%h oor=%b",
                                 $time, exp_pix.red, exp_pix.green, exp_pix.blue,
                                 exp_pix.rgb565, exp_pix.oor);
                        $display("%0t:                got r%h g%h b%h 565=%h oor=%b",
                                 $time, i_red, i_green, i_blue, i_rgb565, i_out_of_range);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: sim/bilinear_scaler_rgb565_core_test.sv
// ----------------------------------------------------------------------------
// bilinear_scaler_rgb565_core_test
// Stimulus and verdict for the scaler: loads missing neighbours before each in-range fetch,
// sweeps register settings and idle patterns, checker runs alongside.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bilinear_scaler_rgb565_core_test;
    import bsr_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_SRC_WIDTH;
    logic [STEP_W-1:0]    i_cfg_data = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_req_type = 1'b0;
    logic [INDEX_W-1:0]   i_src_index = '0;
    logic [PIX_W-1:0]     i_pixel_rgb = '0;
    logic [COORD_W-1:0]   i_dst_x = '0;
    logic [COORD_W-1:0]   i_dst_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [7:0]           o_red, o_green, o_blue;
    logic [15:0]          o_rgb565;
    logic                 o_out_of_range;
    int                   fail_count, pending;

    // stimulus-side view of registers and which store entries hold data
    bit                   loaded [SRC_DEPTH];
    logic [WIDTH_W-1:0]   cur_pitch = WIDTH_W'(320);
    logic [STEP_W-1:0]    cur_xstep = STEP_W'(65536);
    logic [STEP_W-1:0]    cur_ystep = STEP_W'(65536);
    int                   send_idle_pct = 0;
    int                   recv_stall_pct = 0;
    int                   hold_left = 0;
    bit                   hold_go = 0;
    int                   quiet_cycles = 0;

    always #4 i_clk = ~i_clk;

    bilinear_scaler_rgb565_core u_top (.*);

    bilinear_scaler_rgb565_core_check u_check (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_req_type, .i_src_index,
        .i_pixel_rgb, .i_dst_x, .i_dst_y, .i_out_valid(o_out_valid), .i_out_stall,
        .i_red(o_red), .i_green(o_green), .i_blue(o_blue), .i_rgb565(o_rgb565),
        .i_out_of_range(o_out_of_range), .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver: random stall, or a long hold-off when asked
    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_left = 400;
            hold_go   = 0;
        end
        if (hold_left > 0) hold_left--;
        i_out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input beat, after a random idle gap
    task automatic send_beat(input logic kind, input logic [INDEX_W-1:0] sidx,
                             input logic [PIX_W-1:0] pix, input logic [COORD_W-1:0] x,
                             input logic [COORD_W-1:0] y);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_src_index <= sidx;
        i_pixel_rgb <= pix;
        i_dst_x     <= x;
        i_dst_y     <= y;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (!kind) loaded[sidx] = 1;
    endtask

    task automatic load_pixel(input logic [INDEX_W-1:0] sidx, input logic [PIX_W-1:0] pix);
        send_beat(1'b0, sidx, pix, COORD_W'($urandom), COORD_W'($urandom));
    endtask

    // fill any unloaded neighbour, then fetch
    task automatic fetch_pixel(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        longint unsigned px, py, i0, i2;
        longint unsigned taps [4];
        px = longint'(x) * cur_xstep;
        py = longint'(y) * cur_ystep;
        i0 = (py >> FRAC_BITS) * cur_pitch + (px >> FRAC_BITS);
        i2 = i0 + cur_pitch;
        if (i2 + 1 < SRC_DEPTH) begin
            taps = '{i0, i0 + 1, i2, i2 + 1};
            foreach (taps[k])
                if (!loaded[taps[k]]) load_pixel(INDEX_W'(taps[k]), PIX_W'($urandom));
        end
        send_beat(1'b1, INDEX_W'($urandom), PIX_W'($urandom), x, y);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [STEP_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SRC_WIDTH: cur_pitch = val[WIDTH_W-1:0];
            CFG_X_STEP:    cur_xstep = val;
            default:       cur_ystep = val;
        endcase
    endtask

    task automatic set_regs(input int w, input logic [STEP_W-1:0] xs,
                            input logic [STEP_W-1:0] ys);
        drain();
        write_reg(CFG_SRC_WIDTH, STEP_W'(w));
        write_reg(CFG_X_STEP, xs);
        write_reg(CFG_Y_STEP, ys);
    endtask

    // mostly well-formed fetches near the origin, some far, some stray loads
    task automatic random_traffic(input int beats, input int span);
        repeat (beats) begin
            case ($urandom_range(9))
                0, 1:    load_pixel(INDEX_W'($urandom), PIX_W'($urandom));
                2:       fetch_pixel(COORD_W'($urandom), COORD_W'($urandom));
                default: fetch_pixel(COORD_W'($urandom_range(span)),
                                     COORD_W'($urandom_range(span)));
            endcase
        end
    endtask

    task automatic set_idle(input int snd, input int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
    endtask

    initial begin
        int sw, dw;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme pixels and indexes, corners, far fetch
        load_pixel('0, '0);
        load_pixel('1, '1);
        load_pixel(INDEX_W'(1), '1);
        load_pixel(INDEX_W'(320), 24'hA5_5A_C3);
        load_pixel(INDEX_W'(321), 24'h5A_A5_3C);
        fetch_pixel(0, 0);
        fetch_pixel('1, '1);
        fetch_pixel(0, 818);
        fetch_pixel(319, 0);
        fetch_pixel(10, 20);
        set_regs(320, STEP_W'(32768 + 129), STEP_W'(16384 + 77));
        fetch_pixel(1, 1);
        fetch_pixel(3, 5);
        fetch_pixel('1, 0);
        load_pixel(INDEX_W'(2), 24'hFF_00_FF);
        fetch_pixel(2, 3);

        // low extremes of registers, no idling
        set_regs(2, '0, '0);
        random_traffic(100, 1023);
        set_regs(0, STEP_W'(40000), STEP_W'(90000));
        random_traffic(80, 63);

        // high extremes, sender idle
        set_idle(62, 0);
        set_regs(1024, '1, '1);
        random_traffic(100, 3);
        set_regs(2047, STEP_W'(1000), STEP_W'(300));
        random_traffic(100, 255);

        // receiver stalling; long hold-off while the sender keeps going
        set_idle(0, 62);
        set_regs(64, STEP_W'(21000), STEP_W'(45000));
        hold_go = 1;
        random_traffic(90, 63);

        // both idle, then software-style steps from random frame sizes
        set_idle(7, 7);
        repeat (4) begin
            sw = $urandom_range(2, 128);
            dw = $urandom_range(1, 200);
            set_regs(sw, STEP_W'((sw - 1) * 65536 / dw), STEP_W'((sw - 1) * 65536 / dw));
            random_traffic(45, 200);
            set_idle($urandom_range(1) * 62, $urandom_range(1) * 62);
        end

        drain();
        if (fail_count == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
